// ===== rtl/core/unique_tuple_id_assigner_assert.svh =====
// Assertion macros shared by the tuple labeling block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef UNIQUE_TUPLE_ID_ASSIGNER_ASSERT_SVH
`define UNIQUE_TUPLE_ID_ASSIGNER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define UTIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define UTIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/utia_pkg.sv =====
`timescale 1ns / 1ps

package utia_pkg;

    // Table geometry
    localparam int CAPACITY   = 4096;
    localparam int MAX_LAYERS = 8;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int ID_W    = 32;
    localparam int COUNT_W = 48;
    localparam int ROW_W   = MAX_LAYERS * VALUE_W;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int FILL_W  = $clog2(CAPACITY + 1);
    localparam int LAY_W   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int NLAY_W  = $clog2(MAX_LAYERS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int LAYCFG_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LAYERS_USED = CFG_IDX_W'(1);

    localparam logic [LAYCFG_W-1:0] LAYERS_RESET = LAYCFG_W'(8);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Command codes
    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [NLAY_W-1:0] nlay_t;

    // Clamp the layer count register to 1..MAX_LAYERS
    function automatic nlay_t active_layers(input logic [LAYCFG_W-1:0] v);
        nlay_t n;
        if (v == LAYCFG_W'(0)) begin
            n = NLAY_W'(1);
        end else if (32'(v) > MAX_LAYERS) begin
            n = NLAY_W'(MAX_LAYERS);
        end else begin
            n = NLAY_W'(v);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/unique_tuple_id_assigner.sv =====
`timescale 1ns / 1ps
// Tuple labeling table.
// Input channel (in_valid/in_ready): command 0 classifies the pixel tuple in
// layer_value_0..7, command 1 reads back stored entry entry_index.
// Output channel (out_valid/out_ready): one beat per classify; a read of a
// stored entry gives a beat per active layer, one layer value each, last on the
// final one. A read beyond the filled entries gives one beat, entry_valid 0.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 first_id,
// index 1 layers_used. Write it only while the block is idle.
// Search: the table is searched one stored entry at a time through one
// row-wide compare unit on a single read port; each entry passes S_SCAN
// (row read) then S_CMP (compare), and a miss ends in S_MISS. A read passes
// S_RD_ISSUE, then S_RD_EMIT once per beat. in_ready is high only between
// items; a new item is taken while the last beat still waits in the output
// register. A stalled receiver holds the output register and halts the
// sequencer at its next beat. Reset empties the table (fill count to zero),
// sets first_id to 0 and layers_used to 8; no clearing pass is needed.

`include "unique_tuple_id_assigner_assert.svh"

module unique_tuple_id_assigner (
    input  logic                            clk,
    input  logic                            rst_n,
    // Config channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [utia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [utia_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [11:0]                     entry_index,
    input  logic signed [31:0]              layer_value_0,
    input  logic signed [31:0]              layer_value_1,
    input  logic signed [31:0]              layer_value_2,
    input  logic signed [31:0]              layer_value_3,
    input  logic signed [31:0]              layer_value_4,
    input  logic signed [31:0]              layer_value_5,
    input  logic signed [31:0]              layer_value_6,
    input  logic signed [31:0]              layer_value_7,
    // Output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [31:0]                     combo_id,
    output logic [47:0]                     pixel_count,
    output logic                            is_new,
    output logic                            table_full,
    output logic                            entry_valid,
    output logic signed [31:0]              read_value,
    output logic                            last
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE     = 3'd0;
    localparam logic [STATE_W-1:0] S_SCAN     = 3'd1;
    localparam logic [STATE_W-1:0] S_CMP      = 3'd2;
    localparam logic [STATE_W-1:0] S_MISS     = 3'd3;
    localparam logic [STATE_W-1:0] S_RD_ISSUE = 3'd4;
    localparam logic [STATE_W-1:0] S_RD_EMIT  = 3'd5;
    localparam logic [STATE_W-1:0] S_RD_BAD   = 3'd6;

    logic [STATE_W-1:0]              state_reg, state_next;
    logic [utia_pkg::ID_W-1:0]       first_id_reg, first_id_next;
    logic [utia_pkg::LAYCFG_W-1:0]   layers_reg, layers_next;
    logic [utia_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [utia_pkg::IDX_W-1:0]      scan_reg, scan_next;
    logic [utia_pkg::LAY_W-1:0]      lay_reg, lay_next;
    utia_pkg::nlay_t                 n_reg, n_next;
    utia_pkg::row_t                  key_reg, key_next;

    logic                            out_valid_reg, out_valid_next;
    logic [31:0]                     id_reg, id_next;
    logic [47:0]                     cnt_reg, cnt_next;
    logic                            new_reg, new_next;
    logic                            full_reg, full_next;
    logic                            ev_reg, ev_next;
    logic [31:0]                     rv_reg, rv_next;
    logic                            last_reg, last_next;

    logic                            slot_free;
    logic                            load;
    logic                            hit;
    logic                            tuple_we;
    logic                            count_we;
    logic [utia_pkg::IDX_W-1:0]      count_waddr;
    logic [utia_pkg::COUNT_W-1:0]    count_wdata;
    utia_pkg::row_t                  row_rdata;
    logic [utia_pkg::COUNT_W-1:0]    count_rdata;
    logic [utia_pkg::COUNT_W-1:0]    count_inc;
    logic [utia_pkg::IDX_W-1:0]      fill_addr;
    logic [utia_pkg::FILL_W-1:0]     scan_plus;
    utia_pkg::row_t                  key_in;
    utia_pkg::nlay_t                 n_in;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    assign fill_addr = fill_reg[utia_pkg::IDX_W-1:0];
    assign scan_plus = utia_pkg::FILL_W'(scan_reg) + utia_pkg::FILL_W'(1);
    assign count_inc = (count_rdata == utia_pkg::COUNT_MAX) ? count_rdata
                     : count_rdata + utia_pkg::COUNT_W'(1);

    // Pack the incoming layers, zeroing layers beyond the active count
    assign n_in = utia_pkg::active_layers(layers_reg);
    always_comb
    begin
        key_in = {layer_value_7, layer_value_6, layer_value_5, layer_value_4,
                  layer_value_3, layer_value_2, layer_value_1, layer_value_0};
        for (int l = 0; l < utia_pkg::MAX_LAYERS; l++)
        begin
            if (l >= int'(n_in))
            begin
                key_in[l*utia_pkg::VALUE_W +: utia_pkg::VALUE_W] = '0;
            end
        end
    end

    // Tuple rows and occurrence counts
    utia_ram #(
        .WIDTH (utia_pkg::ROW_W),
        .DEPTH (utia_pkg::CAPACITY)
    ) u_tuple_ram (
        .clk   (clk),
        .we    (tuple_we),
        .waddr (fill_addr),
        .wdata (key_reg),
        .raddr (scan_reg),
        .rdata (row_rdata)
    );

    utia_ram #(
        .WIDTH (utia_pkg::COUNT_W),
        .DEPTH (utia_pkg::CAPACITY)
    ) u_count_ram (
        .clk   (clk),
        .we    (count_we),
        .waddr (count_waddr),
        .wdata (count_wdata),
        .raddr (scan_reg),
        .rdata (count_rdata)
    );

    // Shared row compare unit
    utia_match u_match (
        .row (row_rdata),
        .key (key_reg),
        .n   (n_reg),
        .hit (hit)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        first_id_next = first_id_reg;
        layers_next   = layers_reg;
        fill_next     = fill_reg;
        scan_next     = scan_reg;
        lay_next      = lay_reg;
        n_next        = n_reg;
        key_next      = key_reg;
        id_next       = id_reg;
        cnt_next      = cnt_reg;
        new_next      = new_reg;
        full_next     = full_reg;
        ev_next       = ev_reg;
        rv_next       = rv_reg;
        last_next     = last_reg;
        load          = 1'b0;
        tuple_we      = 1'b0;
        count_we      = 1'b0;
        count_waddr   = scan_reg;
        count_wdata   = count_inc;

        // Take config writes
        if (cfg_valid)
        begin
            if (cfg_index == utia_pkg::REG_FIRST_ID)
            begin
                first_id_next = cfg_data[utia_pkg::ID_W-1:0];
            end
            else if (cfg_index == utia_pkg::REG_LAYERS_USED)
            begin
                layers_next = cfg_data[utia_pkg::LAYCFG_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = n_in;
                    key_next = key_in;
                    lay_next = '0;
                    if (command == utia_pkg::CMD_READ)
                    begin
                        scan_next = utia_pkg::IDX_W'(entry_index);
                        if (32'(entry_index) >= 32'(fill_reg))
                        begin
                            state_next = S_RD_BAD;
                        end
                        else
                        begin
                            state_next = S_RD_ISSUE;
                        end
                    end
                    else
                    begin
                        scan_next = '0;
                        if (fill_reg == '0)
                        begin
                            state_next = S_MISS;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (hit)
                begin
                    if (slot_free)
                    begin
                        count_we   = 1'b1;
                        load       = 1'b1;
                        id_next    = first_id_reg + utia_pkg::ID_W'(scan_reg);
                        cnt_next   = count_inc;
                        new_next   = 1'b0;
                        full_next  = 1'b0;
                        ev_next    = 1'b0;
                        rv_next    = '0;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (scan_plus == fill_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    scan_next  = scan_plus[utia_pkg::IDX_W-1:0];
                    state_next = S_SCAN;
                end
            end

            S_MISS:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    ev_next    = 1'b0;
                    rv_next    = '0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                    if (fill_reg == utia_pkg::FILL_W'(utia_pkg::CAPACITY))
                    begin
                        id_next   = '0;
                        cnt_next  = '0;
                        new_next  = 1'b0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        tuple_we    = 1'b1;
                        count_we    = 1'b1;
                        count_waddr = fill_addr;
                        count_wdata = utia_pkg::COUNT_W'(1);
                        fill_next   = fill_reg + utia_pkg::FILL_W'(1);
                        id_next     = first_id_reg + utia_pkg::ID_W'(fill_addr);
                        cnt_next    = utia_pkg::COUNT_W'(1);
                        new_next    = 1'b1;
                        full_next   = 1'b0;
                    end
                end
            end

            S_RD_ISSUE:
            begin
                state_next = S_RD_EMIT;
            end

            S_RD_EMIT:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    id_next   = first_id_reg + utia_pkg::ID_W'(scan_reg);
                    cnt_next  = count_rdata;
                    new_next  = 1'b0;
                    full_next = 1'b0;
                    ev_next   = 1'b1;
                    rv_next   = row_rdata[lay_reg*utia_pkg::VALUE_W +: utia_pkg::VALUE_W];
                    if (utia_pkg::NLAY_W'(lay_reg) + utia_pkg::NLAY_W'(1) == n_reg)
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        last_next = 1'b0;
                        lay_next  = lay_reg + utia_pkg::LAY_W'(1);
                    end
                end
            end

            S_RD_BAD:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    id_next    = '0;
                    cnt_next   = '0;
                    new_next   = 1'b0;
                    full_next  = 1'b0;
                    ev_next    = 1'b0;
                    rv_next    = '0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Fill or drain the output register
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_id_reg  <= '0;
            layers_reg    <= utia_pkg::LAYERS_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_id_reg  <= first_id_next;
            layers_reg    <= layers_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        lay_reg  <= lay_next;
        n_reg    <= n_next;
        key_reg  <= key_next;
        id_reg   <= id_next;
        cnt_reg  <= cnt_next;
        new_reg  <= new_next;
        full_reg <= full_next;
        ev_reg   <= ev_next;
        rv_reg   <= rv_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign combo_id    = id_reg;
    assign pixel_count = cnt_reg;
    assign is_new      = new_reg;
    assign table_full  = full_reg;
    assign entry_valid = ev_reg;
    assign read_value  = rv_reg;
    assign last        = last_reg;

    `UTIA_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= utia_pkg::FILL_W'(utia_pkg::CAPACITY), "fill count beyond capacity")
    `UTIA_ASSERT_NEXT(a_fill_step, tuple_we, fill_reg == $past(fill_reg) + utia_pkg::FILL_W'(1), "insert did not advance fill count")
    `UTIA_ASSERT_NOW(a_scan_bound, (state_reg == S_SCAN) || (state_reg == S_CMP), utia_pkg::FILL_W'(scan_reg) < fill_reg, "scan beyond filled entries")
    `UTIA_ASSERT_NOW(a_new_count, out_valid_reg && new_reg, (cnt_reg == utia_pkg::COUNT_W'(1)) && !full_reg && last_reg, "new entry beat malformed")

endmodule

// ===== rtl/core/utia_ram.sv =====
`timescale 1ns / 1ps

module utia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/utia_match.sv =====
`timescale 1ns / 1ps

module utia_match (
    input  utia_pkg::row_t  row,
    input  utia_pkg::row_t  key,
    input  utia_pkg::nlay_t n,
    output logic            hit
);

    // Compare the active layers of a stored row against the search key
    always_comb
    begin
        hit = 1'b1;
        for (int l = 0; l < utia_pkg::MAX_LAYERS; l++)
        begin
            if ((l < int'(n)) &&
                (row[l*utia_pkg::VALUE_W +: utia_pkg::VALUE_W] !=
                 key[l*utia_pkg::VALUE_W +: utia_pkg::VALUE_W]))
            begin
                hit = 1'b0;
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import utia_pkg::*;

    localparam int LONG_STALL = 500;
    localparam int TAIL_CYCLES = 64;
    localparam int LIMIT_NS = 8_000_000;
    localparam int BATCH = 64;

    typedef logic [MAX_LAYERS-1:0][VALUE_W-1:0] tuple_t;

    typedef struct packed {
        logic        cmd;
        logic [11:0] index;
        tuple_t      layer;
    } pixel_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
        logic               fresh;
        logic               full;
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               fin;
    } label_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               command = CMD_CLASSIFY;
    logic [11:0]        entry_index = '0;
    logic signed [31:0] layer_value_0 = '0;
    logic signed [31:0] layer_value_1 = '0;
    logic signed [31:0] layer_value_2 = '0;
    logic signed [31:0] layer_value_3 = '0;
    logic signed [31:0] layer_value_4 = '0;
    logic signed [31:0] layer_value_5 = '0;
    logic signed [31:0] layer_value_6 = '0;
    logic signed [31:0] layer_value_7 = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        combo_id;
    logic [47:0]        pixel_count;
    logic               is_new;
    logic               table_full;
    logic               entry_valid;
    logic signed [31:0] read_value;
    logic               last;

    // Commands waiting to be offered, and output beats still owed
    pixel_cmd_t  cmd_q[$];
    label_beat_t beats_due[$];
    pixel_cmd_t  offered;
    tuple_t      tuple_pool[$];

    // Shadow copy of the table and its registers
    tuple_t              shadow_tuple[CAPACITY];
    logic [COUNT_W-1:0]  shadow_count[CAPACITY];
    int                  shadow_filled = 0;
    logic [ID_W-1:0]     shadow_first_id = '0;
    logic [LAYCFG_W-1:0] shadow_layers = LAYERS_RESET;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req = 1'b0;
    logic recv_hold = 1'b0;
    int   fail_count = 0;

    unique_tuple_id_assigner dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .entry_index(entry_index),
        .layer_value_0(layer_value_0),
        .layer_value_1(layer_value_1),
        .layer_value_2(layer_value_2),
        .layer_value_3(layer_value_3),
        .layer_value_4(layer_value_4),
        .layer_value_5(layer_value_5),
        .layer_value_6(layer_value_6),
        .layer_value_7(layer_value_7),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .combo_id(combo_id),
        .pixel_count(pixel_count),
        .is_new(is_new),
        .table_full(table_full),
        .entry_valid(entry_valid),
        .read_value(read_value),
        .last(last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Work out the beats one accepted command owes and update the shadow table
    task automatic label_command(input pixel_cmd_t c);
        int          n;
        int          e;
        int          l;
        int          hit;
        bit          same;
        label_beat_t b;
        if (shadow_layers == '0)
            n = 1;
        else if (int'(shadow_layers) > MAX_LAYERS)
            n = MAX_LAYERS;
        else
            n = int'(shadow_layers);
        b = '0;
        if (c.cmd == CMD_READ)
        begin
            if (int'(c.index) >= shadow_filled)
            begin
                b.fin = 1'b1;
                beats_due.push_back(b);
            end
            else
            begin
                // one beat per active layer, last on the final one
                for (l = 0; l < n; l++)
                begin
                    b.id = shadow_first_id + ID_W'(c.index);
                    b.count = shadow_count[c.index];
                    b.valid = 1'b1;
                    b.value = shadow_tuple[c.index][l];
                    b.fin = (l == n - 1);
                    beats_due.push_back(b);
                end
            end
        end
        else
        begin
            // search stored entries in insertion order on the active layers
            hit = -1;
            for (e = 0; e < shadow_filled && hit < 0; e++)
            begin
                same = 1'b1;
                for (l = 0; l < n; l++)
                    if (shadow_tuple[e][l] != c.layer[l])
                        same = 1'b0;
                if (same)
                    hit = e;
            end
            b.fin = 1'b1;
            if (hit >= 0)
            begin
                if (shadow_count[hit] != COUNT_MAX)
                    shadow_count[hit] = shadow_count[hit] + COUNT_W'(1);
                b.id = shadow_first_id + ID_W'(hit);
                b.count = shadow_count[hit];
            end
            else if (shadow_filled >= CAPACITY)
            begin
                b.full = 1'b1;
            end
            else
            begin
                // store the active layers, zero the rest
                for (l = 0; l < MAX_LAYERS; l++)
                    shadow_tuple[shadow_filled][l] = (l < n) ? c.layer[l] : '0;
                shadow_count[shadow_filled] = COUNT_W'(1);
                b.id = shadow_first_id + ID_W'(shadow_filled);
                b.count = COUNT_W'(1);
                b.fresh = 1'b1;
                shadow_filled++;
            end
            beats_due.push_back(b);
        end
    endtask

    // Input driver: predict on acceptance, then offer the next command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                label_command(offered);
            if (!in_valid || in_ready)
            begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = cmd_q.pop_front();
                    command <= offered.cmd;
                    entry_index <= offered.index;
                    layer_value_0 <= offered.layer[0];
                    layer_value_1 <= offered.layer[1];
                    layer_value_2 <= offered.layer[2];
                    layer_value_3 <= offered.layer[3];
                    layer_value_4 <= offered.layer[4];
                    layer_value_5 <= offered.layer[5];
                    layer_value_6 <= offered.layer[6];
                    layer_value_7 <= offered.layer[7];
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each beat against the oldest one owed
    always @(posedge clk or negedge rst_n)
    begin : out_monitor
        label_beat_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (beats_due.size() == 0)
                begin
                    $error("beat with nothing owed: combo_id %h", combo_id);
                    fail_count++;
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (combo_id !== want.id)
                    begin
                        $error("combo_id: expected %h, got %h", want.id, combo_id);
                        fail_count++;
                    end
                    if (pixel_count !== want.count)
                    begin
                        $error("pixel_count: expected %h, got %h", want.count, pixel_count);
                        fail_count++;
                    end
                    if (is_new !== want.fresh)
                    begin
                        $error("is_new: expected %b, got %b", want.fresh, is_new);
                        fail_count++;
                    end
                    if (table_full !== want.full)
                    begin
                        $error("table_full: expected %b, got %b", want.full, table_full);
                        fail_count++;
                    end
                    if (entry_valid !== want.valid)
                    begin
                        $error("entry_valid: expected %b, got %b", want.valid, entry_valid);
                        fail_count++;
                    end
                    if (read_value !== want.value)
                    begin
                        $error("read_value: expected %h, got %h", want.value, read_value);
                        fail_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %b, got %b", want.fin, last);
                        fail_count++;
                    end
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here once requested
    initial
    begin
        wait (hold_req);
        @(negedge clk);
        recv_hold = 1'b1;
        repeat (LONG_STALL) @(negedge clk);
        recv_hold = 1'b0;
    end

    // Hard stop for a hung run
    initial
    begin
        #(LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Write one register beat; the block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FIRST_ID)
            shadow_first_id = data;
        else if (idx == REG_LAYERS_USED)
            shadow_layers = data[LAYCFG_W-1:0];
        @(negedge clk);
    endtask

    task automatic queue_classify(input tuple_t v);
        pixel_cmd_t c;
        c.cmd = CMD_CLASSIFY;
        c.index = 12'($urandom);
        c.layer = v;
        cmd_q.push_back(c);
    endtask

    task automatic queue_read(input logic [11:0] idx);
        pixel_cmd_t c;
        c.cmd = CMD_READ;
        c.index = idx;
        c.layer = tuple_t'({$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom});
        cmd_q.push_back(c);
    endtask

    // Random tuple, leaning on sign and range extremes
    function automatic tuple_t random_tuple();
        tuple_t v;
        int     l;
        for (l = 0; l < MAX_LAYERS; l++)
        begin
            case ($urandom_range(9))
                0: v[l] = 32'h8000_0000;
                1: v[l] = 32'h7FFF_FFFF;
                2: v[l] = 32'hFFFF_FFFF;
                3: v[l] = 32'h0000_0000;
                default: v[l] = $urandom;
            endcase
        end
        return v;
    endfunction

    // Mostly repeats of known tuples, some near misses, fresh tuples and reads
    task automatic random_batch(input int count);
        int     i;
        int     r;
        tuple_t t;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 55 && tuple_pool.size() != 0)
            begin
                queue_classify(tuple_pool[$urandom_range(tuple_pool.size() - 1)]);
            end
            else if (r < 65 && tuple_pool.size() != 0)
            begin
                t = tuple_pool[$urandom_range(tuple_pool.size() - 1)];
                t[$urandom_range(MAX_LAYERS - 1)] = $urandom;
                tuple_pool.push_back(t);
                queue_classify(t);
            end
            else if (r < 78)
            begin
                t = random_tuple();
                tuple_pool.push_back(t);
                queue_classify(t);
            end
            else if (r < 93)
            begin
                queue_read(12'($urandom_range(tuple_pool.size())));
            end
            else
            begin
                queue_read(12'($urandom_range(4095)));
            end
        end
    endtask

    // Wait until every command is taken and every owed beat has come
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || in_valid || beats_due.size() != 0);
    endtask

    initial
    begin
        tuple_t t;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset defaults, all eight layers compared
        send_idle_pct = 8;
        recv_idle_pct = 75;
        queue_read(12'd0);
        queue_classify('0);
        queue_classify('0);
        queue_classify({MAX_LAYERS{32'h8000_0000}});
        queue_classify({MAX_LAYERS{32'h7FFF_FFFF}});
        queue_classify({MAX_LAYERS{32'hFFFF_FFFF}});
        queue_classify({4{32'hAAAA_AAAA, 32'h5555_5555}});
        queue_classify({32'd1, {(MAX_LAYERS - 1){32'd0}}});
        queue_classify({MAX_LAYERS{32'h7FFF_FFFF}});
        queue_read(12'd2);
        queue_read(12'd5);
        queue_read(12'd6);
        queue_read(12'd4095);
        drain();

        // One layer compared, IDs wrap past the top
        write_reg(REG_FIRST_ID, 32'hFFFF_FFFE);
        write_reg(REG_LAYERS_USED, 32'd1);
        t = random_tuple();
        t[0] = 32'h0000_0000;
        queue_classify(t);
        t[0] = 32'h8000_0000;
        queue_classify(t);
        t[0] = 32'h7FFF_FFFF;
        queue_classify(t);
        t = random_tuple();
        t[0] = 32'd12345;
        queue_classify(t);
        queue_read(12'd6);
        queue_read(12'd0);
        drain();

        // Zero layer count acts as one
        write_reg(REG_LAYERS_USED, 32'd0);
        queue_read(12'd3);
        t = random_tuple();
        t[0] = 32'hFFFF_FFFF;
        queue_classify(t);
        drain();

        // Oversized layer count acts as eight; unused layers were stored as zero
        write_reg(REG_LAYERS_USED, 32'hFFFF_FFFF);
        queue_read(12'd6);
        queue_classify({{(MAX_LAYERS - 1){32'd0}}, 32'd12345});
        queue_read(12'd0);
        drain();

        // Random, sender rarely idle, receiver mostly idle
        write_reg(REG_FIRST_ID, $urandom);
        write_reg(REG_LAYERS_USED, 32'({$urandom, 4'($urandom_range(2, 7))}));
        random_batch(BATCH);
        drain();

        // Random, roles swapped, IDs wrap during the batch
        send_idle_pct = 75;
        recv_idle_pct = 8;
        write_reg(REG_FIRST_ID, 32'hFFFF_FFF0);
        write_reg(REG_LAYERS_USED, 32'd8);
        random_batch(BATCH);
        drain();

        // No idling, but the receiver holds off long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_FIRST_ID, $urandom);
        write_reg(REG_LAYERS_USED, 32'({$urandom, 4'($urandom_range(15))}));
        hold_req = 1'b1;
        random_batch(BATCH);
        drain();

        write_reg(REG_FIRST_ID, 32'h0000_0000);
        write_reg(REG_LAYERS_USED, 32'd3);
        random_batch(BATCH);
        drain();

        // Catch any stray beat after the last one owed
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && beats_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
